// ===== sv/snw_pkg.sv =====
// Shared types and constants of the Spanish word normalizer.
// Holds the channel payloads, the queue token and the stopword table.
// No dependencies.
`default_nettype none

package snw_pkg;

    localparam int MAX_WORD_BYTES_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int TOKEN_BYTES = 4;
    localparam int STOP_COUNT = 40;
    localparam int STOP_MAX_LEN = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_t;

    typedef struct packed {
        logic [TOKEN_BYTES-1:0][7:0] data;
        logic [2:0]                  count;
        logic                        last;
    } token_t;

    localparam logic [63:0] STOP_TEXT [STOP_COUNT] = '{
        64'("Y"), 64'("O"), 64'("EL"), 64'("LA"), 64'("LOS"), 64'("LAS"), 64'("UN"),
        64'("UNA"), 64'("UNOS"), 64'("UNAS"), 64'("A"), 64'("ANTE"), 64'("BAJO"),
        64'("CON"), 64'("CONTRA"), 64'("DE"), 64'("DESDE"), 64'("DURANTE"), 64'("EN"),
        64'("ENTRE"), 64'("HACIA"), 64'("HASTA"), 64'("MEDIANTE"), 64'("PARA"),
        64'("POR"), 64'("SEGUN"), 64'("SIN"), 64'("SOBRE"), 64'("TRAS"), 64'("QUE"),
        64'("LE"), 64'("LES"), 64'("DEL"), 64'("AL"), 64'("CUANDO"), 64'("SU"),
        64'("SUS"), 64'("COMO"), 64'("O"), 64'("MAS")
    };

    localparam logic [3:0] STOP_LEN [STOP_COUNT] = '{
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd2, 4'd3, 4'd4, 4'd4,
        4'd1, 4'd4, 4'd4, 4'd3, 4'd6, 4'd2, 4'd5, 4'd7, 4'd2,
        4'd5, 4'd5, 4'd5, 4'd8, 4'd4, 4'd3, 4'd5, 4'd3,
        4'd5, 4'd4, 4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd6, 4'd2, 4'd3,
        4'd4, 4'd1, 4'd3
    };

    // Character i of stopword k, counted from its first letter.
    function automatic logic [7:0] stop_byte(input int k, input logic [2:0] i);
        int sh;
        sh = 8 * (int'(STOP_LEN[k]) - 1 - int'(i));
        if (sh < 0) begin
            return 8'h00;
        end
        return STOP_TEXT[k][sh +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/snw_front.sv =====
// Front end of the normalizer: widens Latin-1 input, normalizes each character
// and turns each accepted byte that yields bytes or ends a word into a token.
// Depends on snw_pkg.
`default_nettype none

module snw_front
    import snw_pkg::*;
#(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEFAULT
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   cfg_valid,
    input  wire logic   cfg_data,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire in_t    s_data,
    output logic        push_valid,
    input  wire logic   push_ready,
    output token_t      push_data
);

    localparam int PW = $clog2(MAX_WORD_BYTES + 3);
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] DOT = 8'h2E;
    localparam logic [7:0] TILDE_SECOND = 8'h91;
    localparam logic [7:0] CLS_NONE = 8'h00;
    localparam logic [7:0] CLS_N = 8'h4E;

    typedef struct packed {
        logic [PW-1:0] pos;
        logic          pl;
        logic          pd;
        logic [1:0]    n;
        logic [7:0]    b0;
        logic [7:0]    b1;
    } feed_t;

    logic          latin1_mode_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic          pl_reg, pl_next;
    logic          pd_reg, pd_next;
    feed_t         f0, f1, f2;
    logic          wide;
    logic          accept;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [7:0] second_class(input logic [7:0] b);
        logic [7:0] c;
        unique case (b)
            8'h81, 8'hA1:               c = 8'h41;
            8'h89, 8'hA9:               c = 8'h45;
            8'h8D, 8'hAD:               c = 8'h49;
            8'h93, 8'hB3:               c = 8'h4F;
            8'h9A, 8'hBA, 8'h9C, 8'hBC: c = 8'h55;
            8'h91, 8'hB1:               c = CLS_N;
            default:                    c = CLS_NONE;
        endcase
        return c;
    endfunction

    function automatic feed_t push(input feed_t f, input logic [7:0] b);
        feed_t r;
        r = f;
        if (f.n == 2'd0) begin
            r.b0 = b;
        end else begin
            r.b1 = b;
        end
        r.n = f.n + 2'd1;
        return r;
    endfunction

    function automatic feed_t feed(input logic [PW-1:0] pos, input logic pl,
                                   input logic pd, input logic [7:0] b);
        feed_t      r;
        logic       start;
        logic [7:0] cls;
        r = '{pos: pos, pl: pl, pd: pd, n: 2'd0, b0: 8'h00, b1: 8'h00};
        if (pos > PW'(MAX_WORD_BYTES + 1)) begin
            return r;
        end
        r.pos = pos + PW'(1);
        start = (pos <= PW'(MAX_WORD_BYTES));
        cls = second_class(b);
        if (pd) begin
            r.pd = 1'b0;
            if (b == LEAD_C3 || is_alnum(b)) begin
                r = push(r, DOT);
            end
        end else if (pl) begin
            r.pl = 1'b0;
            if (cls == CLS_N) begin
                r = push(r, LEAD_C3);
                r = push(r, TILDE_SECOND);
                start = 1'b0;
            end else if (cls != CLS_NONE) begin
                r = push(r, cls);
                start = 1'b0;
            end
        end
        if (start) begin
            if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39)) begin
                r = push(r, b);
            end else if (b >= 8'h61 && b <= 8'h7A) begin
                r = push(r, b - 8'h20);
            end else if (b == DOT) begin
                r.pd = 1'b1;
            end else if (b == LEAD_C3) begin
                r.pl = 1'b1;
            end
        end
        return r;
    endfunction

    assign wide = latin1_mode_reg && s_data.in_byte[7];

    always_comb begin
        f0 = feed(pos_reg, pl_reg, pd_reg, s_data.in_byte);
        f1 = feed(pos_reg, pl_reg, pd_reg, {6'b110000, s_data.in_byte[7:6]});
        f2 = feed(f1.pos, f1.pl, f1.pd, {2'b10, s_data.in_byte[5:0]});
        push_data.last = s_data.last_byte;
        push_data.data = '0;
        if (wide) begin
            push_data.count = {1'b0, f1.n} + {1'b0, f2.n};
            unique case (f1.n)
                2'd0: begin
                    push_data.data[0] = f2.b0;
                    push_data.data[1] = f2.b1;
                end
                2'd1: begin
                    push_data.data[0] = f1.b0;
                    push_data.data[1] = f2.b0;
                    push_data.data[2] = f2.b1;
                end
                default: begin
                    push_data.data[0] = f1.b0;
                    push_data.data[1] = f1.b1;
                    push_data.data[2] = f2.b0;
                    push_data.data[3] = f2.b1;
                end
            endcase
            pos_next = f2.pos;
            pl_next = f2.pl;
            pd_next = f2.pd;
        end else begin
            push_data.count = {1'b0, f0.n};
            push_data.data[0] = f0.b0;
            push_data.data[1] = f0.b1;
            pos_next = f0.pos;
            pl_next = f0.pl;
            pd_next = f0.pd;
        end
        if (s_data.last_byte) begin
            pos_next = '0;
            pl_next = 1'b0;
            pd_next = 1'b0;
        end
    end

    assign s_ready = push_ready;
    assign accept = s_valid && push_ready;
    assign push_valid = s_valid && (push_data.count != 3'd0 || s_data.last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latin1_mode_reg <= 1'b0;
            pos_reg <= '0;
            pl_reg <= 1'b0;
            pd_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                latin1_mode_reg <= cfg_data;
            end
            if (accept) begin
                pos_reg <= pos_next;
                pl_reg <= pl_next;
                pd_reg <= pd_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/snw_queue.sv =====
// Short token queue that decouples the front end from the back end.
// Depends on snw_pkg.
`default_nettype none

module snw_queue
    import snw_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire token_t push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output token_t      pop_data
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    token_t         slots [QUEUE_DEPTH];
    logic [QA-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QC-1:0]  fill_reg;
    logic           do_push, do_pop;

    assign push_ready = fill_reg != QC'(QUEUE_DEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_data = slots[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QA'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QA'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QA'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QA'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QC'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QC'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/snw_back.sv =====
// Back end of the normalizer: stores token bytes in the word buffer, tracks
// stopword matches byte by byte and emits the word or a single invalid beat.
// Depends on snw_pkg.
`default_nettype none

module snw_back
    import snw_pkg::*;
#(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEFAULT
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    input  wire token_t pop_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_t        m_data
);

    localparam int BUF_LEN = MAX_WORD_BYTES + 2;
    localparam int AW = $clog2(BUF_LEN);
    localparam int LW = $clog2(BUF_LEN + 1);

    localparam logic [1:0] ST_LOAD    = 2'd0;
    localparam logic [1:0] ST_DECIDE  = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    logic [7:0]            word_mem [BUF_LEN];
    logic [1:0]            state_reg, state_next;
    logic [1:0]            sub_reg, sub_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [AW-1:0]         rd_reg, rd_next;
    logic [STOP_COUNT-1:0] match_reg, match_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg;
    logic [STOP_COUNT-1:0] hit, len_eq;
    logic [7:0]            cur_byte;
    logic                  take, has_byte, tok_end, wr_en, out_free, is_stop;
    logic                  load_emit, load_invalid, final_beat;

    assign cur_byte = pop_data.data[sub_reg];
    assign has_byte = pop_data.count != 3'd0;
    assign tok_end = !has_byte || ({1'b0, sub_reg} + 3'd1 == pop_data.count);
    assign take = (state_reg == ST_LOAD) && pop_valid;
    assign wr_en = take && has_byte && (len_reg < LW'(BUF_LEN));
    assign pop_ready = take && tok_end;
    assign out_free = !m_valid_reg || m_ready;
    assign final_beat = (LW'(rd_reg) + LW'(1)) == len_reg;
    assign load_emit = (state_reg == ST_EMIT) && out_free;
    assign load_invalid = (state_reg == ST_INVALID) && out_free;

    always_comb begin
        for (int k = 0; k < STOP_COUNT; k++) begin
            hit[k] = (len_reg < LW'(STOP_LEN[k])) &&
                     (stop_byte(k, len_reg[2:0]) == cur_byte);
            len_eq[k] = len_reg == LW'(STOP_LEN[k]);
        end
        is_stop = |(match_reg & len_eq);
    end

    always_comb begin
        state_next = state_reg;
        sub_next = sub_reg;
        len_next = len_reg;
        rd_next = rd_reg;
        match_next = match_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (take) begin
                    if (has_byte) begin
                        match_next = match_reg & hit;
                        sub_next = tok_end ? 2'd0 : sub_reg + 2'd1;
                    end
                    if (wr_en) begin
                        len_next = len_reg + LW'(1);
                    end
                    if (tok_end && pop_data.last) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                rd_next = '0;
                state_next = (len_reg == '0 || is_stop) ? ST_INVALID : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rd_next = rd_reg + AW'(1);
                    if (final_beat) begin
                        state_next = ST_LOAD;
                        len_next = '0;
                        match_next = '1;
                    end
                end
            end
            default: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next = ST_LOAD;
                    len_next = '0;
                    match_next = '1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem[len_reg[AW-1:0]] <= cur_byte;
        end
        if (load_emit) begin
            m_data_reg.out_byte <= word_mem[rd_reg];
            m_data_reg.out_valid <= 1'b1;
            m_data_reg.out_last <= final_beat;
        end else if (load_invalid) begin
            m_data_reg.out_byte <= 8'h00;
            m_data_reg.out_valid <= 1'b0;
            m_data_reg.out_last <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sub_reg <= '0;
            len_reg <= '0;
            rd_reg <= '0;
            match_reg <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg <= sub_next;
            len_reg <= len_next;
            rd_reg <= rd_next;
            match_reg <= match_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/spanish_word_normalizer_unit.sv =====
// Input bytes are taken one per cycle while the four-token queue has room.
// The back end stores one normalized byte per cycle while tokens are queued,
// passes through a decision state at the end of a word, then emits one output
// beat per cycle while the output is free, registered in the emit state.
// Synchronous active-low reset clears all control state; the word buffer is
// not cleared, as only written entries are ever read.
`default_nettype none

module spanish_word_normalizer_unit
    import snw_pkg::*;
#(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic   push_valid, push_ready, pop_valid, pop_ready;
    token_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    snw_front #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    snw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    snw_back #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
